### src/mbrtu_pkg.sv
// shared types, constants and crc helper for the modbus rtu slave frame handler
package mbrtu_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int REG_COUNT_DEF   = 5;
    localparam int MAX_READ        = 29;
    localparam int REPLY_W         = 7;

    localparam logic [7:0]  FC_READ       = 8'h03;
    localparam logic [7:0]  FC_WRITE      = 8'h06;
    localparam logic [7:0]  FC_READ_EXC   = 8'h83;
    localparam logic [7:0]  FC_WRITE_EXC  = 8'h86;
    localparam logic [7:0]  FC_OTHER_EXC  = 8'h80;
    localparam logic [7:0]  EXC_ADDR      = 8'h02;
    localparam logic [7:0]  EXC_FUNC      = 8'h01;
    localparam logic [7:0]  IDLE_LIMIT_RST = 8'h05;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic        CMD_BYTE      = 1'b0;
    localparam logic        CMD_TICK      = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RP_READ,
        RP_WRITE,
        RP_EXC
    } t_reply;

    // one byte of the reflected crc-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### src/modbus_rtu_slave_frame_handler_core.sv
// modbus rtu slave: frame store, idle timing, crc check and reply sequencer
//
// input beats (s_axis): tuser selects the kind, 0 = received line byte, 1 = timer tick.
//   tdata[7:0] is the line byte, tdata[15:8] the milliseconds elapsed since the last tick.
// output beats (m_axis): one reply byte per beat in line order, tlast on the final byte.
// config: i_cfg_we writes i_cfg_wdata as the idle limit in ms (reset value 5, 0 acts as 1).
// line bytes go straight into the frame memory, one beat per cycle while idle, bytes past the
// memory depth are dropped. a tick that reaches the idle limit closes the frame.
// closing walks the frame memory one byte per cycle through the crc unit, then
// checks it; a frame shorter than 4 bytes or with a bad crc is dropped. otherwise
// the reply is sent one byte per cycle while the receiver is ready, from a sequencer
// that folds each byte before the crc into the running crc and reads register
// data from a small memory. after a closing tick the input is held through scan,
// check and the reply (longest reply 15 bytes); no input beat is taken while a
// frame is scanned or a reply built.
// a stalled receiver holds the output register, the sequencer waits on it.
// reset (synchronous, active low) empties the frame, clears timers and marks all
// registers of the group as zero through valid bits; the frame memory is not cleared.
module modbus_rtu_slave_frame_handler_core
    import mbrtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] rx_byte, [15:8] elapsed_ms
    input  logic        i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] tx_byte
    output logic        o_m_axis_tlast
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // storage
    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] reg_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_reg_vld;
    logic [7:0] r_mem_q;
    logic [7:0] r_reg_q;
    logic       r_reg_q_vld;

    // control
    t_state r_state, n_state;
    logic [7:0]  r_limit;
    logic [CW-1:0] r_byte_cnt, r_seen, r_len;
    logic [7:0]  r_timer;
    logic [CW-1:0] r_rd_idx, r_proc_idx;
    logic        r_pend;
    logic [7:0]  r_hdr [6];
    logic [7:0]  r_rx_lo, r_rx_hi;
    logic [15:0] r_crc;
    t_reply      r_kind;
    logic [7:0]  r_code, r_exc;
    logic [REPLY_W-1:0] r_k, r_n;
    logic [RW-1:0] r_reg_ptr;
    logic        r_out_valid, r_out_last;
    logic [7:0]  r_out_data;

    logic        w_in_acc, w_close, w_issue, w_load, w_reg_rd;
    logic [7:0]  w_limit, w_tx;
    logic [8:0]  w_sum;
    logic [7:0]  w_sum_sat;
    logic [15:0] w_cnt;
    logic        w_read_ok, w_write_ok, w_crc_ok;
    logic [CW-1:0] w_len_m2, w_len_m1;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_limit  = (r_limit == 8'd0) ? 8'd1 : r_limit;
    assign w_sum    = {1'b0, r_timer} + {1'b0, i_s_axis_tdata[15:8]};
    assign w_sum_sat = w_sum[8] ? 8'hFF : w_sum[7:0];

    // tick that reaches the idle limit
    assign w_close = w_in_acc && (i_s_axis_tuser == CMD_TICK) && (r_byte_cnt != '0)
                     && (r_seen == r_byte_cnt) && (r_timer < w_limit)
                     && (w_sum_sat >= w_limit);

    assign w_len_m2 = r_len - CW'(2);
    assign w_len_m1 = r_len - CW'(1);
    assign w_issue  = (r_state == ST_SCAN) && (r_rd_idx < r_len);

    assign w_cnt    = {r_hdr[4], r_hdr[5]};
    assign w_read_ok = (r_hdr[2] == 8'd0)
                       && (({9'd0, r_hdr[3]} + {1'b0, w_cnt}) <= 17'(REG_COUNT))
                       && (w_cnt <= 16'(MAX_READ));
    assign w_write_ok = (r_hdr[2] == 8'd0) && ({1'b0, r_hdr[3]} <= 9'(REG_COUNT));
    assign w_crc_ok  = ({r_rx_hi, r_rx_lo} == r_crc);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_close && (r_byte_cnt >= CW'(4))) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pend && (r_proc_idx == w_len_m1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_crc_ok ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (w_load && (r_k == r_n - REPLY_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // reply byte sequencer outputs
    assign w_load = (r_state == ST_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign w_reg_rd = w_load && (r_kind == RP_READ) && (r_k >= REPLY_W'(3))
                      && (r_k < r_n - REPLY_W'(2)) && r_k[0];

    always_comb begin
        w_tx = 8'h00;
        if (r_k == r_n - REPLY_W'(2)) begin
            w_tx = r_crc[7:0];
        end else if (r_k == r_n - REPLY_W'(1)) begin
            w_tx = r_crc[15:8];
        end else begin
            case (r_kind)
                RP_READ: begin
                    if (r_k == REPLY_W'(0)) begin
                        w_tx = r_hdr[0];
                    end else if (r_k == REPLY_W'(1)) begin
                        w_tx = FC_READ;
                    end else if (r_k == REPLY_W'(2)) begin
                        w_tx = {r_hdr[5][6:0], 1'b0};
                    end else if (r_k[0]) begin
                        w_tx = 8'h00;
                    end else begin
                        w_tx = r_reg_q_vld ? r_reg_q : 8'h00;
                    end
                end
                RP_WRITE: begin
                    case (r_k[2:0])
                        3'd0: w_tx = r_hdr[0];
                        3'd1: w_tx = r_hdr[1];
                        3'd2: w_tx = r_hdr[2];
                        3'd3: w_tx = r_hdr[3];
                        3'd4: w_tx = r_hdr[4];
                        3'd5: w_tx = r_hdr[5];
                        default: w_tx = 8'h00;
                    endcase
                end
                RP_EXC: begin
                    if (r_k == REPLY_W'(0)) begin
                        w_tx = r_hdr[0];
                    end else if (r_k == REPLY_W'(1)) begin
                        w_tx = r_code;
                    end else begin
                        w_tx = r_exc;
                    end
                end
                default: w_tx = 8'h00;
            endcase
        end
    end

    // frame memory: byte writes while idle, one read per cycle during scan
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_s_axis_tuser == CMD_BYTE) && (r_byte_cnt < CW'(FRAME_BYTES))) begin
            frame_mem[r_byte_cnt[AW-1:0]] <= i_s_axis_tdata[7:0];
        end
        r_mem_q <= frame_mem[r_rd_idx[AW-1:0]];
    end

    // register group memory, valid bits stand in for the reset value
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_CHECK) && w_crc_ok && (r_hdr[1] == FC_WRITE) && w_write_ok
            && ({1'b0, r_hdr[3]} < 9'(REG_COUNT))) begin
            reg_mem[r_hdr[3][RW-1:0]] <= r_hdr[5];
        end
        if (w_reg_rd) begin
            r_reg_q <= reg_mem[r_reg_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld   <= '0;
            r_reg_q_vld <= 1'b0;
        end else begin
            if ((r_state == ST_CHECK) && w_crc_ok && (r_hdr[1] == FC_WRITE) && w_write_ok
                && ({1'b0, r_hdr[3]} < 9'(REG_COUNT))) begin
                r_reg_vld[r_hdr[3][RW-1:0]] <= 1'b1;
            end
            if (w_reg_rd) begin
                r_reg_q_vld <= r_reg_vld[r_reg_ptr];
            end
        end
    end

    // control and timing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= IDLE_LIMIT_RST;
            r_byte_cnt  <= '0;
            r_seen      <= '0;
            r_timer     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                if (i_s_axis_tuser == CMD_BYTE) begin
                    if (r_byte_cnt < CW'(FRAME_BYTES)) begin
                        r_byte_cnt <= r_byte_cnt + CW'(1);
                    end
                end else if (r_byte_cnt == '0) begin
                    r_seen <= '0;
                end else if (r_seen != r_byte_cnt) begin
                    r_seen  <= r_byte_cnt;
                    r_timer <= '0;
                end else if (w_close) begin
                    r_byte_cnt <= '0;
                    r_seen     <= '0;
                    r_timer    <= '0;
                end else if (r_timer < w_limit) begin
                    r_timer <= w_sum_sat;
                end
            end
            r_pend <= w_issue;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan and reply datapath
    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_len    <= r_byte_cnt;
            r_rd_idx <= '0;
            r_crc    <= CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                r_hdr[i] <= 8'h00;
            end
        end
        if (w_issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        r_proc_idx <= r_rd_idx;
        if ((r_state == ST_SCAN) && r_pend) begin
            if (r_proc_idx < w_len_m2) begin
                r_crc <= crc_byte(r_crc, r_mem_q);
            end
            if (r_proc_idx < CW'(6)) begin
                r_hdr[r_proc_idx[2:0]] <= r_mem_q;
            end
            if (r_proc_idx == w_len_m2) begin
                r_rx_lo <= r_mem_q;
            end
            if (r_proc_idx == w_len_m1) begin
                r_rx_hi <= r_mem_q;
            end
        end
        if (r_state == ST_CHECK) begin
            r_crc     <= CRC_INIT;
            r_k       <= '0;
            r_reg_ptr <= r_hdr[3][RW-1:0];
            r_exc     <= EXC_ADDR;
            if (r_hdr[1] == FC_READ) begin
                if (w_read_ok) begin
                    r_kind <= RP_READ;
                    r_n    <= REPLY_W'(5) + {r_hdr[5][5:0], 1'b0};
                end else begin
                    r_kind <= RP_EXC;
                    r_code <= FC_READ_EXC;
                    r_n    <= REPLY_W'(5);
                end
            end else if (r_hdr[1] == FC_WRITE) begin
                if (w_write_ok) begin
                    r_kind <= RP_WRITE;
                    r_n    <= REPLY_W'(8);
                end else begin
                    r_kind <= RP_EXC;
                    r_code <= FC_WRITE_EXC;
                    r_n    <= REPLY_W'(5);
                end
            end else begin
                r_kind <= RP_EXC;
                r_code <= FC_OTHER_EXC;
                r_exc  <= EXC_FUNC;
                r_n    <= REPLY_W'(5);
            end
        end
        if (w_load) begin
            r_out_data <= w_tx;
            r_out_last <= (r_k == r_n - REPLY_W'(1));
            r_k        <= r_k + REPLY_W'(1);
            if (r_k < r_n - REPLY_W'(2)) begin
                r_crc <= crc_byte(r_crc, w_tx);
            end
            if (w_reg_rd) begin
                r_reg_ptr <= r_reg_ptr + RW'(1);
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= CW'(FRAME_BYTES))
        else $error("frame byte count past depth");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && $past(r_state) == ST_IDLE) |-> (r_byte_cnt == '0 && r_timer == '0))
        else $error("frame close left counters set");

    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_k < r_n))
        else $error("reply position past reply length");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_CHECK) |-> !o_s_axis_tready)
        else $error("input taken during frame scan");

endmodule
